@@ src/tlhfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlhfs_pkg
// Shared types, codes and constants of the trace line header field splitter.
// ----------------------------------------------------------------------------
package tlhfs_pkg;

    localparam int MAX_PARTS_DEFAULT = 64;
    localparam int LEGACY_PARTS      = 5;
    localparam int PREFIX_LEN        = 5;
    localparam int OUT_TDATA_W       = 136;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_MODULE  = 2'd1;
    localparam logic [1:0] KIND_BODY    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_NOT_TRACE  = 4'd1;
    localparam logic [3:0] ST_INCOMPLETE = 4'd2;
    localparam logic [3:0] ST_NO_DASH    = 4'd3;
    localparam logic [3:0] ST_NO_MAJOR   = 4'd4;
    localparam logic [3:0] ST_MAJOR_ZERO = 4'd5;
    localparam logic [3:0] ST_NO_DOT     = 4'd6;
    localparam logic [3:0] ST_NO_MINOR   = 4'd7;
    localparam logic [3:0] ST_NO_BRACKET = 4'd8;

    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_PLUS     = 8'h2B;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         char_out;
        logic [5:0]         part;
        logic               last;
        logic               versioned;
        logic [3:0]         status;
        logic [15:0]        major;
        logic [15:0]        minor;
        logic [7:0]         module_length;
        logic [6:0]         part_count;
        logic signed [31:0] line_number;
        logic signed [31:0] process_id;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] lead_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h5B;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h66;
            3'd4:    b = 8'h6C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ src/tlhfs_in_stage.sv @@
// ----------------------------------------------------------------------------
// tlhfs_in_stage
// Input register: holds one accepted transaction until the parser takes it.
// ----------------------------------------------------------------------------
module tlhfs_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tlhfs_pkg::item_t in_item,
    output logic           item_valid,
    output tlhfs_pkg::item_t item,
    input  logic           take
);
    import tlhfs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/tlhfs_parser.sv @@
// ----------------------------------------------------------------------------
// tlhfs_parser
// Per-line parse state and the combinational step that yields up to two results.
// ----------------------------------------------------------------------------
module tlhfs_parser
#(
    parameter int MAX_PARTS = tlhfs_pkg::MAX_PARTS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  tlhfs_pkg::item_t  item,
    input  logic [1:0]        space,
    output logic              take,
    output tlhfs_pkg::push_t  push
);
    import tlhfs_pkg::*;

    localparam int PW = $clog2(MAX_PARTS + 1);

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_LEGACY,
        PH_MODULE,
        PH_MAJ_FIRST,
        PH_MAJ,
        PH_MIN_FIRST,
        PH_MIN,
        PH_VBODY,
        PH_IGNORE
    } phase_t;

    phase_t         phase_reg,      phase_next;
    logic [2:0]     prefix_pos_reg, prefix_pos_next;
    logic           versioned_reg,  versioned_next;
    logic [3:0]     error_reg,      error_next;
    logic [15:0]    major_reg,      major_next;
    logic [15:0]    minor_reg,      minor_next;
    logic [7:0]     module_cnt_reg, module_cnt_next;
    logic [PW-1:0]  part_idx_reg,   part_idx_next;
    logic           escape_reg,     escape_next;
    logic [31:0]    line_acc_reg,   line_acc_next;
    logic [2:0]     line_conv_reg,  line_conv_next;
    logic [31:0]    pid_acc_reg,    pid_acc_next;
    logic [2:0]     pid_conv_reg,   pid_conv_next;

    logic [1:0]     n_res;
    result_t        r0;
    result_t        r1;
    result_t        body_r;
    result_t        sum_r;
    logic           op;
    logic [7:0]     c;
    logic           emit;
    logic [PW-1:0]  pc;
    logic [PW+6:0]  pc_ext;
    logic [PW+5:0]  part_ext;
    logic [3:0]     st;
    logic [34:0]    line_fed;
    logic [34:0]    pid_fed;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    endfunction

    function automatic logic [15:0] ver_add(input logic [15:0] acc, input logic [7:0] ch);
        logic [19:0] v;
        v = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(ch[3:0]);
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // atoi step: returns {conv, acc}; conv = {stage[1:0], neg}
    function automatic logic [34:0] conv_feed(input logic [31:0] acc,
                                              input logic [2:0]  cv,
                                              input logic [7:0]  ch);
        logic [1:0]  stage;
        logic        neg;
        logic        go;
        logic [31:0] a;
        logic [2:0]  v;
        logic [31:0] lim;
        logic [34:0] prod;
        stage = cv[2:1];
        neg   = cv[0];
        go    = 1'b1;
        a     = acc;
        v     = cv;
        lim   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        prod  = 35'({a, 3'b000}) + 35'({a, 1'b0}) + 35'(ch[3:0]);
        if (stage == 2'd0)
        begin
            if (is_blank(ch))
            begin
                go = 1'b0;
            end
            else if (ch == CH_PLUS)
            begin
                v  = 3'd2;
                go = 1'b0;
            end
            else if (ch == CH_DASH)
            begin
                v  = 3'd3;
                go = 1'b0;
            end
            else
            begin
                stage = 2'd1;
                v     = {2'b01, neg};
            end
        end
        if (go && (stage == 2'd1))
        begin
            if (is_digit(ch))
            begin
                a = (prod > 35'(lim)) ? lim : prod[31:0];
            end
            else
            begin
                v = {2'b10, neg};
            end
        end
        return {v, a};
    endfunction

    assign op       = item.op;
    assign c        = item.char_in;
    assign part_ext = {6'b0, part_idx_reg};
    assign pc       = part_idx_reg + PW'(1);
    assign pc_ext   = {7'b0, pc};
    assign line_fed = conv_feed(line_acc_reg, line_conv_reg, c);
    assign pid_fed  = conv_feed(pid_acc_reg, pid_conv_reg, c);

    always_comb
    begin
        body_r           = '0;
        body_r.kind      = KIND_BODY;
        body_r.char_out  = c;
        body_r.part      = part_ext[5:0];
        body_r.versioned = versioned_reg;

        case (phase_reg)
            PH_PREFIX:    st = ST_NOT_TRACE;
            PH_MODULE:    st = ST_NO_DASH;
            PH_MAJ_FIRST: st = ST_NO_MAJOR;
            PH_MAJ:       st = (major_reg == 16'd0) ? ST_MAJOR_ZERO : ST_NO_DOT;
            PH_MIN_FIRST: st = ST_NO_MINOR;
            PH_MIN:       st = ST_NO_BRACKET;
            PH_LEGACY,
            PH_VBODY:     st = (pc >= PW'(4)) ? ST_OK : ST_INCOMPLETE;
            default:      st = error_reg;
        endcase

        sum_r               = '0;
        sum_r.kind          = KIND_SUMMARY;
        sum_r.last          = 1'b1;
        sum_r.versioned     = versioned_reg;
        sum_r.status        = st;
        sum_r.major         = major_reg;
        sum_r.minor         = minor_reg;
        sum_r.module_length = module_cnt_reg;
        sum_r.part_count    = ((phase_reg == PH_LEGACY) || (phase_reg == PH_VBODY))
                              ? pc_ext[6:0] : 7'd0;
        sum_r.line_number   = line_conv_reg[0] ? (32'd0 - line_acc_reg) : line_acc_reg;
        sum_r.process_id    = pid_conv_reg[0] ? (32'd0 - pid_acc_reg) : pid_acc_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        prefix_pos_next = prefix_pos_reg;
        versioned_next  = versioned_reg;
        error_next      = error_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        module_cnt_next = module_cnt_reg;
        part_idx_next   = part_idx_reg;
        escape_next     = escape_reg;
        line_acc_next   = line_acc_reg;
        line_conv_next  = line_conv_reg;
        pid_acc_next    = pid_acc_reg;
        pid_conv_next   = pid_conv_reg;
        n_res           = 2'd0;
        r0              = '0;
        r1              = '0;
        emit            = 1'b0;

        if (!op)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (prefix_pos_reg < 3'(PREFIX_LEN))
                    begin
                        if (c == lead_byte(prefix_pos_reg))
                        begin
                            prefix_pos_next = prefix_pos_reg + 3'd1;
                        end
                        else
                        begin
                            error_next = ST_NOT_TRACE;
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (c == CH_RBRACKET)
                    begin
                        phase_next = PH_LEGACY;
                    end
                    else if (c == CH_DASH)
                    begin
                        versioned_next = 1'b1;
                        phase_next     = PH_MODULE;
                    end
                    else
                    begin
                        error_next = ST_NOT_TRACE;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_MODULE:
                begin
                    if (is_letter(c))
                    begin
                        if (module_cnt_reg != 8'hFF)
                        begin
                            module_cnt_next = module_cnt_reg + 8'd1;
                        end
                        n_res        = 2'd1;
                        r0           = '0;
                        r0.kind      = KIND_MODULE;
                        r0.char_out  = c;
                        r0.last      = 1'b1;
                        r0.versioned = versioned_reg;
                    end
                    else if (c == CH_DASH)
                    begin
                        phase_next = PH_MAJ_FIRST;
                    end
                    else
                    begin
                        error_next = ST_NO_DASH;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_MAJ_FIRST:
                begin
                    if (is_digit(c))
                    begin
                        major_next = ver_add(major_reg, c);
                        phase_next = PH_MAJ;
                    end
                    else
                    begin
                        error_next = ST_NO_MAJOR;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_MAJ:
                begin
                    if (is_digit(c))
                    begin
                        major_next = ver_add(major_reg, c);
                    end
                    else if (major_reg == 16'd0)
                    begin
                        error_next = ST_MAJOR_ZERO;
                        phase_next = PH_IGNORE;
                    end
                    else if (c == CH_DOT)
                    begin
                        phase_next = PH_MIN_FIRST;
                    end
                    else
                    begin
                        error_next = ST_NO_DOT;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_MIN_FIRST:
                begin
                    if (is_digit(c))
                    begin
                        minor_next = ver_add(minor_reg, c);
                        phase_next = PH_MIN;
                    end
                    else
                    begin
                        error_next = ST_NO_MINOR;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_MIN:
                begin
                    if (is_digit(c))
                    begin
                        minor_next = ver_add(minor_reg, c);
                    end
                    else if (c == CH_RBRACKET)
                    begin
                        phase_next = PH_VBODY;
                    end
                    else
                    begin
                        error_next = ST_NO_BRACKET;
                        phase_next = PH_IGNORE;
                    end
                end
                PH_LEGACY:
                begin
                    if ((c == CH_COLON) && (part_idx_reg < PW'(LEGACY_PARTS - 1)))
                    begin
                        part_idx_next = part_idx_reg + PW'(1);
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                PH_VBODY:
                begin
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        emit        = 1'b1;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escape_next = 1'b1;
                    end
                    else if (c == CH_COLON)
                    begin
                        if (part_idx_reg < PW'(MAX_PARTS - 1))
                        begin
                            part_idx_next = part_idx_reg + PW'(1);
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (emit)
            begin
                n_res   = 2'd1;
                r0      = body_r;
                r0.last = 1'b1;
                if (part_idx_reg == PW'(1))
                begin
                    line_conv_next = line_fed[34:32];
                    line_acc_next  = line_fed[31:0];
                end
                else if (part_idx_reg == PW'(2))
                begin
                    pid_conv_next = pid_fed[34:32];
                    pid_acc_next  = pid_fed[31:0];
                end
            end
        end
        else
        begin
            // trailing backslash goes out as a body character ahead of the summary
            if ((phase_reg == PH_VBODY) && escape_reg)
            begin
                n_res       = 2'd2;
                r0          = body_r;
                r0.char_out = CH_BSLASH;
                r1          = sum_r;
            end
            else
            begin
                n_res = 2'd1;
                r0    = sum_r;
            end
            phase_next      = PH_PREFIX;
            prefix_pos_next = 3'd0;
            versioned_next  = 1'b0;
            error_next      = ST_OK;
            major_next      = 16'd0;
            minor_next      = 16'd0;
            module_cnt_next = 8'd0;
            part_idx_next   = '0;
            escape_next     = 1'b0;
            line_acc_next   = 32'd0;
            line_conv_next  = 3'd0;
            pid_acc_next    = 32'd0;
            pid_conv_next   = 3'd0;
        end
    end

    assign take     = item_valid && (n_res <= space);
    assign push.cnt = take ? n_res : 2'd0;
    assign push.r0  = r0;
    assign push.r1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PREFIX;
            prefix_pos_reg <= 3'd0;
            versioned_reg  <= 1'b0;
            error_reg      <= ST_OK;
            major_reg      <= 16'd0;
            minor_reg      <= 16'd0;
            module_cnt_reg <= 8'd0;
            part_idx_reg   <= '0;
            escape_reg     <= 1'b0;
            line_acc_reg   <= 32'd0;
            line_conv_reg  <= 3'd0;
            pid_acc_reg    <= 32'd0;
            pid_conv_reg   <= 3'd0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            prefix_pos_reg <= prefix_pos_next;
            versioned_reg  <= versioned_next;
            error_reg      <= error_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            module_cnt_reg <= module_cnt_next;
            part_idx_reg   <= part_idx_next;
            escape_reg     <= escape_next;
            line_acc_reg   <= line_acc_next;
            line_conv_reg  <= line_conv_next;
            pid_acc_reg    <= pid_acc_next;
            pid_conv_reg   <= pid_conv_next;
        end
    end

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt <= space)
        else $error("push exceeds free result slots");

    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.r0.kind == KIND_BODY && push.r1.kind == KIND_SUMMARY)
        else $error("two-result push is not body then summary");

    a_escape_only_vbody: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> phase_reg == PH_VBODY)
        else $error("escape pending outside versioned body");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.op |=> phase_reg == PH_PREFIX && part_idx_reg == '0)
        else $error("line state not cleared after end of line");

endmodule

@@ src/tlhfs_out_buf.sv @@
// ----------------------------------------------------------------------------
// tlhfs_out_buf
// Two-entry result register; takes up to two results per transaction.
// ----------------------------------------------------------------------------
module tlhfs_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlhfs_pkg::push_t   push,
    output logic [1:0]         space,
    output logic               out_valid,
    input  logic               out_ready,
    output tlhfs_pkg::result_t head
);
    import tlhfs_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot_reg  [2];
    result_t    slot_next [2];
    logic       pop;
    logic [1:0] base;

    assign pop   = (cnt_reg != 2'd0) && out_ready;
    assign space = 2'd2 - cnt_reg + {1'b0, pop};
    assign base  = cnt_reg - {1'b0, pop};

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (push.cnt != 2'd0)
        begin
            slot_next[base[0]] = push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            slot_next[1] = push.r1;
        end
        cnt_next = base + push.cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot_reg[0];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    a_head_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> slot_reg[0].kind != KIND_NONE)
        else $error("empty kind at buffer head");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 && slot_reg[0].kind == KIND_SUMMARY |-> slot_reg[0].last)
        else $error("summary without last flag");

endmodule

@@ src/trace_line_header_field_splitter.sv @@
// ----------------------------------------------------------------------------
// trace_line_header_field_splitter
// Parses trace line headers byte by byte and splits the body into parts.
// ----------------------------------------------------------------------------
// One character transaction is taken every clock cycle unless the output
// stalls it. Each is registered, parsed by a combinational step against the
// per-line state, and its result (if any) lands in a two-entry result
// register, from which the output is presented. An end-of-line
// transaction that closes a versioned line with a pending backslash yields
// two results; the result register absorbs them, and with the output always
// ready the input rate stays at one transaction per cycle. Backpressure on
// the output stalls the input once the result register is full, or has room
// for only one of the two results of such an end-of-line transaction.
module trace_line_header_field_splitter
#(
    parameter int MAX_PARTS = tlhfs_pkg::MAX_PARTS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // char_in
    input  logic [0:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // char_out, part, versioned, status, major, minor, module_length,
    // part_count, line_number, process_id, zero fill
    output logic [tlhfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast
);
    import tlhfs_pkg::*;

    item_t      in_item;
    item_t      item;
    logic       item_valid;
    logic       take;
    logic [1:0] space;
    push_t      push;
    result_t    head;

    assign in_item.op      = s_axis_tuser[0];
    assign in_item.char_in = s_axis_tdata;

    tlhfs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    tlhfs_parser #(.MAX_PARTS(MAX_PARTS)) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .space      (space),
        .take       (take),
        .push       (push)
    );

    tlhfs_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .head      (head)
    );

    assign m_axis_tdata = {6'b0,
                           head.process_id,
                           head.line_number,
                           head.part_count,
                           head.module_length,
                           head.minor,
                           head.major,
                           head.status,
                           head.versioned,
                           head.part,
                           head.char_out};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
